FILE: hw/rtl/bpc_pkg.sv
// Shared types, constants and arithmetic helpers for the barometric compensation block.
// No dependencies.
`default_nettype none
package bpc_pkg;
  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
  } bpc_in_t;

  typedef struct packed {
    logic signed [31:0] temperature_tenths;
    logic signed [31:0] pressure_pa;
    logic calibration_invalid;
    logic divide_fault;
  } bpc_out_t;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
    logic [1:0] oss;
  } bpc_job_t;

  localparam logic [1:0] CFG_GROUP_A = 2'd0;
  localparam logic [1:0] CFG_GROUP_B = 2'd1;
  localparam logic [1:0] CFG_GROUP_C = 2'd2;
  localparam logic [1:0] CFG_OSS = 2'd3;
  localparam int QueueDepth = 2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_X1, ST_DIVT, ST_WAITT, ST_B6, ST_SQ, ST_P1, ST_P2, ST_P3, ST_B4,
    ST_DIVP, ST_WAITP, ST_C1, ST_C2, ST_C3, ST_DONE
  } bpc_state_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    sx16 = {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
    asr = 32'($signed(x) >>> n);
  endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/baro_pressure_temp_compensation.sv
// Top level of the barometric compensation block: configuration registers,
// front queue and back datapath. Depends on bpc_pkg, bpc_front, bpc_back.
//
// Usage:
//   A request (raw temperature and pressure) is taken on a clock edge where
//   in_start is high and in_busy is low. Requests go into a two-entry queue;
//   in_busy is high only while the queue is full.
//   Each request gives one result on out_data, marked by out_valid for one
//   cycle. The receiver cannot stall.
//   The back end works on one request at a time: both divisions use the shared
//   bit-serial divider, and the sequencer runs the multiply steps around them.
//   Further requests wait in the queue meanwhile. A zero temperature divisor
//   skips both divisions and a zero pressure divisor skips the second; the
//   sequencer then goes straight to the result, with divide_fault set.
//   Configuration is written through cfg_we, cfg_index and cfg_wdata while the
//   block is idle and applies to the next request.
//   Synchronous reset clears the queue and sequencer, coefficients to 0 and
//   oversampling to 3.
`default_nettype none
module baro_pressure_temp_compensation import bpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_start,
  output logic             in_busy,
  input  wire bpc_in_t     in_data,
  output logic             out_valid,
  output bpc_out_t         out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata
);
  logic [63:0] cal_a_r, cal_b_r;
  logic [47:0] cal_c_r;
  logic [1:0]  oss_r;
  logic        full, avail, pop;
  bpc_job_t    head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_a_r <= '0;
      cal_b_r <= '0;
      cal_c_r <= '0;
      oss_r <= 2'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GROUP_A: cal_a_r <= cfg_wdata;
        CFG_GROUP_B: cal_b_r <= cfg_wdata;
        CFG_GROUP_C: cal_c_r <= cfg_wdata[47:0];
        CFG_OSS:     oss_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  assign in_busy = full;

  bpc_front u_front (
    .clk(clk), .rst_n(rst_n), .push(in_start && !full), .in_data(in_data),
    .oss(oss_r), .full(full), .pop(pop), .avail(avail), .head(head)
  );

  bpc_back u_back (
    .clk(clk), .rst_n(rst_n), .avail(avail), .job(head), .pop(pop),
    .cal_a(cal_a_r), .cal_b(cal_b_r), .cal_c(cal_c_r),
    .out_valid(out_valid), .out_data(out_data)
  );
endmodule
`default_nettype wire

FILE: hw/rtl/bpc_div.sv
// Iterative unsigned 32-bit divider, one quotient bit per cycle.
// Depends on bpc_pkg.
`default_nettype none
module bpc_div import bpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        go,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  logic [31:0] rem_r, rem_nxt, q_r, q_nxt, d_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt, done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    rem_nxt = rem_r;
    q_nxt = q_r;
    cnt_nxt = cnt_r;
    run_nxt = run_r;
    done_nxt = 1'b0;
    trial = {rem_r, q_r[31]} - {1'b0, d_r};
    if (go) begin
      rem_nxt = '0;
      q_nxt = dividend;
      cnt_nxt = 6'd32;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], q_r[31]};
        q_nxt = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        run_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      run_r <= run_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    if (go) d_r <= divisor;
  end

  assign done = done_r;
  assign quotient = q_r;
endmodule
`default_nettype wire

FILE: hw/rtl/bpc_front.sv
// Front end: accepts requests, captures oversampling and queues them.
// Depends on bpc_pkg.
`default_nettype none
module bpc_front import bpc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire bpc_in_t  in_data,
  input  wire logic [1:0] oss,
  output logic          full,
  input  wire logic     pop,
  output logic          avail,
  output bpc_job_t      head
);
  bpc_job_t q_r [QueueDepth];
  logic rd_r, wr_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) q_r[wr_r] <= '{in_data.raw_temperature, in_data.raw_pressure, oss};
  end

  assign full = cnt_r == 2'(QueueDepth);
  assign avail = cnt_r != 2'd0;
  assign head = q_r[rd_r];
endmodule
`default_nettype wire

FILE: hw/rtl/bpc_back.sv
// Back end: sequenced compensation datapath with a shared iterative divider.
// Depends on bpc_pkg and bpc_div.
`default_nettype none
module bpc_back import bpc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        avail,
  input  wire bpc_job_t    job,
  output logic             pop,
  input  wire logic [63:0] cal_a,
  input  wire logic [63:0] cal_b,
  input  wire logic [47:0] cal_c,
  output logic             out_valid,
  output bpc_out_t         out_data
);
  bpc_state_t st_r, st_nxt;
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mb, mc, md;
  logic [31:0] x1_r, b5_r, b6_r, sq_r, x3_r, b3_r, p_r, t_r, y_r, up_r;
  logic [1:0]  oss_r;
  logic [15:0] ut_r;
  logic        neg_r, big_r, fault_r;
  logic        dgo, ddone;
  logic [31:0] dnum, dden, dq, mta, mtb, prod;
  logic [31:0] divt, ma, qs;
  logic [31:0] b4_full, b4_w;

  assign ac1 = sx16(cal_a[63:48]);
  assign ac2 = sx16(cal_a[47:32]);
  assign ac3 = sx16(cal_a[31:16]);
  assign ac4 = {16'd0, cal_a[15:0]};
  assign ac5 = {16'd0, cal_b[63:48]};
  assign ac6 = {16'd0, cal_b[47:32]};
  assign b1 = sx16(cal_b[31:16]);
  assign b2 = sx16(cal_b[15:0]);
  assign mb = sx16(cal_c[47:32]);
  assign mc = sx16(cal_c[31:16]);
  assign md = sx16(cal_c[15:0]);
  assign divt = x1_r + md;
  assign ma = (mc << 11);

  bpc_div u_div (
    .clk(clk), .rst_n(rst_n), .go(dgo), .dividend(dnum), .divisor(dden),
    .done(ddone), .quotient(dq)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (avail) st_nxt = ST_X1;
      ST_X1:    st_nxt = ST_DIVT;
      ST_DIVT:  st_nxt = (divt == 32'd0) ? ST_DONE : ST_WAITT;
      ST_WAITT: if (ddone) st_nxt = ST_B6;
      ST_B6:    st_nxt = ST_SQ;
      ST_SQ:    st_nxt = ST_P1;
      ST_P1:    st_nxt = ST_P2;
      ST_P2:    st_nxt = ST_P3;
      ST_P3:    st_nxt = ST_B4;
      ST_B4:    st_nxt = ST_DIVP;
      ST_DIVP:  st_nxt = (b4_w == 32'd0) ? ST_DONE : ST_WAITP;
      ST_WAITP: if (ddone) st_nxt = ST_C1;
      ST_C1:    st_nxt = ST_C2;
      ST_C2:    st_nxt = ST_C3;
      ST_C3:    st_nxt = ST_DONE;
      ST_DONE:  st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pop = (st_r == ST_IDLE) && avail;
    dgo = 1'b0;
    dnum = '0;
    dden = '0;
    if (st_r == ST_DIVT && divt != 32'd0) begin
      dgo = 1'b1;
      dnum = ma[31] ? 32'(0 - ma) : ma;
      dden = divt[31] ? 32'(0 - divt) : divt;
    end
    if (st_r == ST_DIVP && b4_w != 32'd0) begin
      dgo = 1'b1;
      dnum = prod[31] ? prod : {prod[30:0], 1'b0};
      dden = b4_w;
    end
  end

  always_comb begin
    mta = '0;
    mtb = '0;
    case (st_r)
      ST_X1:   begin mta = {16'd0, ut_r} - ac6; mtb = ac5; end
      ST_SQ:   begin mta = b6_r; mtb = b6_r; end
      ST_P1:   begin mta = b2; mtb = sq_r; end
      ST_P2:   begin mta = ac2; mtb = b6_r; end
      ST_P3:   begin mta = ac3; mtb = b6_r; end
      ST_B4:   begin mta = b1; mtb = sq_r; end
      ST_DIVP: begin mta = up_r - b3_r; mtb = 32'd50000 >> oss_r; end
      ST_C1:   begin mta = asr(qs, 5'd8); mtb = asr(qs, 5'd8); end
      ST_C2:   begin mta = y_r; mtb = 32'd3038; end
      ST_C3:   begin mta = 32'(0 - 7357); mtb = p_r; end
      default: begin mta = '0; mtb = '0; end
    endcase
    prod = 32'(mta * mtb);
  end

  assign qs = big_r ? {dq[30:0], 1'b0} : dq;
  assign b4_full = 32'(ac4 * (asr(x1_r + y_r + 32'd2, 5'd2) + 32'd32768));
  assign b4_w = b4_full >> 15;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid <= st_r == ST_DONE;
    end
    case (st_r)
      ST_IDLE: begin
        ut_r <= job.raw_temperature;
        up_r <= 32'({8'd0, job.raw_pressure} >> (4'd8 - {2'd0, job.oss}));
        oss_r <= job.oss;
        fault_r <= 1'b0;
        t_r <= '0;
        p_r <= '0;
      end
      ST_X1: x1_r <= asr(prod, 5'd15);
      ST_DIVT: begin
        neg_r <= ma[31] ^ divt[31];
        if (divt == 32'd0) fault_r <= 1'b1;
      end
      ST_WAITT: if (ddone) b5_r <= x1_r + (neg_r ? 32'(0 - dq) : dq);
      ST_B6: begin
        t_r <= asr(b5_r + 32'd8, 5'd4);
        b6_r <= b5_r - 32'd4000;
      end
      ST_SQ: sq_r <= asr(prod, 5'd12);
      ST_P1: x1_r <= asr(prod, 5'd11);
      ST_P2: x3_r <= x1_r + asr(prod, 5'd11);
      ST_P3: begin
        b3_r <= asr((((ac1 << 2) + x3_r) << oss_r) + 32'd2, 5'd2);
        x1_r <= asr(prod, 5'd13);
      end
      ST_B4: y_r <= asr(prod, 5'd16);
      ST_DIVP: begin
        big_r <= prod[31];
        if (b4_w == 32'd0) fault_r <= 1'b1;
      end
      ST_C1: begin
        p_r <= qs;
        y_r <= prod;
      end
      ST_C2: y_r <= asr(prod, 5'd16);
      ST_C3: p_r <= p_r + asr(y_r + asr(prod, 5'd16) + 32'd3791, 5'd4);
      ST_DONE: begin
        out_data.temperature_tenths <= fault_r ? '0 : t_r;
        out_data.pressure_pa <= fault_r ? '0 : p_r;
        out_data.divide_fault <= fault_r;
        out_data.calibration_invalid <= (ac1 == 0) || (ac2 == 0) || (ac3 == 0) ||
          (ac4 == 0) || (ac5 == 0) || (ac6 == 0) || (b1 == 0) || (b2 == 0) ||
          (mb == 0) || (mc == 0) || (md == 0);
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire
